// ----- src/rtfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtfp_pkg
// Types, constants and arithmetic helpers for the RGBA texel format packer.
// ----------------------------------------------------------------------------
package rtfp_pkg;

    localparam int PAD_ALIGN = 8;
    localparam int PHASE_W   = (PAD_ALIGN > 1) ? $clog2(PAD_ALIGN) : 1;

    localparam logic [15:0] LUMA_R = 16'd19661;
    localparam logic [15:0] LUMA_G = 16'd38666;
    localparam logic [15:0] LUMA_B = 16'd7209;

    localparam logic [7:0] THR_RESET = 8'd192;

    localparam logic [4:0] LEVELS_3 = 5'd7;
    localparam logic [4:0] LEVELS_4 = 5'd15;
    localparam logic [4:0] LEVELS_5 = 5'd31;

    localparam logic REG_FORMAT    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef enum logic [2:0] {
        FMT_I4     = 3'd0,
        FMT_I8     = 3'd1,
        FMT_IA4    = 3'd2,
        FMT_IA8    = 3'd3,
        FMT_IA16   = 3'd4,
        FMT_RGBA16 = 3'd5,
        FMT_RGBA32 = 3'd6
    } t_fmt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_SCALE,
        S_BUILD,
        S_EMIT,
        S_PAD
    } t_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_texel;

    // floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // round to nearest of v * levels / 255
    function automatic logic [4:0] quant(input logic [7:0] v, input logic [4:0] levels);
        logic [15:0] n;
        logic [7:0]  q;
        n = ({8'b0, v} * {11'b0, levels}) + 16'd127;
        q = div255(n);
        return q[4:0];
    endfunction

endpackage

// ----- src/rgba_texel_format_packer.sv -----
// ----------------------------------------------------------------------------
// rgba_texel_format_packer
// Converts RGBA8888 pixels into big-endian texel bytes (I4, I8, IA4, IA8,
// IA16, RGBA16, RGBA32), with nibble pairing and end-of-image padding.
// ----------------------------------------------------------------------------
// Each pixel yields B bytes (0 to 4, plus the flushed nibble byte and the
// zero padding up to a multiple of PAD_ALIGN bytes on the last pixel). The
// pixel is taken in (S_IDLE), the luma is accumulated through one shared
// 16x8 multiplier over red, green and blue (S_MAC), the multiplier is reused
// for the alpha scaling (S_SCALE), the bytes are formed (S_BUILD), then the
// output register takes one byte a cycle, longer while the receiver stalls.
// The next pixel is taken in the cycle after the last byte of the previous
// one enters the output register, or after S_BUILD if it yields no byte.
module rgba_texel_format_packer
    import rtfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_pixel      i_word,
    output logic        o_stall,
    output logic        o_valid,
    output t_texel      o_word,
    input  logic        i_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state             r_state, n_state;
    t_fmt               r_fmt;
    logic [7:0]         r_thr;
    t_pixel             r_pix;
    logic [1:0]         r_step;
    logic [23:0]        r_acc;
    logic [7:0]         r_luma;
    logic [3:0]         r_held;
    logic               r_odd;
    logic [PHASE_W-1:0] r_phase;
    logic [7:0]         r_buf [4];
    logic [2:0]         r_cnt;
    logic [1:0]         r_idx;
    logic               r_ovalid;
    t_texel             r_oword;

    logic [15:0]        w_mul_a;
    logic [7:0]         w_mul_b;
    logic [23:0]        w_prod;
    logic [7:0]         w_scaled;
    logic               w_opaque;
    logic [3:0]         w_nib;
    logic               w_nib_fmt;
    logic [15:0]        w_rgba16;
    logic [7:0]         w_buf [4];
    logic [2:0]         w_cnt;
    logic [3:0]         w_held;
    logic               w_odd;
    logic               w_slot_free;
    logic               w_load;
    logic [7:0]         w_byte;
    logic               w_flag;
    logic [PHASE_W-1:0] w_phase_next;
    logic               w_emit_done;
    logic               w_accept;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_FORMAT) ? {29'b0, r_fmt} : {24'b0, r_thr};

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_word   = r_oword;

    // shared multiplier
    always_comb begin
        w_mul_a = {8'b0, r_luma};
        w_mul_b = r_pix.alpha;
        if (r_state == S_MAC) begin
            unique case (r_step)
                2'd0:    begin w_mul_a = LUMA_R; w_mul_b = r_pix.red;   end
                2'd1:    begin w_mul_a = LUMA_G; w_mul_b = r_pix.green; end
                default: begin w_mul_a = LUMA_B; w_mul_b = r_pix.blue;  end
            endcase
        end
        w_prod = {8'b0, w_mul_a} * {16'b0, w_mul_b};
    end

    // byte formation
    always_comb begin
        w_scaled  = div255(r_acc[15:0]);
        w_opaque  = (r_pix.alpha >= r_thr);
        w_rgba16  = {quant(r_pix.red, LEVELS_5), quant(r_pix.green, LEVELS_5),
                     quant(r_pix.blue, LEVELS_5), w_opaque};
        w_nib     = 4'b0;
        w_nib_fmt = 1'b0;
        w_buf[0]  = 8'b0;
        w_buf[1]  = 8'b0;
        w_buf[2]  = 8'b0;
        w_buf[3]  = 8'b0;
        w_cnt     = 3'd0;
        w_held    = 4'b0;
        w_odd     = 1'b0;
        unique case (r_fmt)
            FMT_I4: begin
                w_nib_fmt = 1'b1;
                w_nib     = 4'(quant(w_scaled, LEVELS_4));
            end
            FMT_IA4: begin
                w_nib_fmt = 1'b1;
                w_nib     = {3'(quant(r_luma, LEVELS_3)), w_opaque};
            end
            FMT_I8: begin
                w_buf[0] = w_scaled;
                w_cnt    = 3'd1;
            end
            FMT_IA8: begin
                w_buf[0] = {4'(quant(r_luma, LEVELS_4)), 4'(quant(r_pix.alpha, LEVELS_4))};
                w_cnt    = 3'd1;
            end
            FMT_IA16: begin
                w_buf[0] = r_luma;
                w_buf[1] = r_pix.alpha;
                w_cnt    = 3'd2;
            end
            FMT_RGBA16: begin
                w_buf[0] = w_rgba16[15:8];
                w_buf[1] = w_rgba16[7:0];
                w_cnt    = 3'd2;
            end
            FMT_RGBA32: begin
                w_buf[0] = r_pix.red;
                w_buf[1] = r_pix.green;
                w_buf[2] = r_pix.blue;
                w_buf[3] = r_pix.alpha;
                w_cnt    = 3'd4;
            end
            default: begin
                w_cnt = 3'd0;
            end
        endcase
        if (w_nib_fmt) begin
            if (r_odd) begin
                w_buf[0] = {r_held, w_nib};
                w_cnt    = 3'd1;
            end else begin
                w_held = w_nib;
                w_odd  = 1'b1;
            end
        end
        if (r_pix.last_pixel) begin
            if (w_odd) begin
                w_buf[0] = {w_held, 4'b0};
                w_cnt    = 3'd1;
            end
            w_held = 4'b0;
            w_odd  = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MAC;
            S_MAC:   if (r_step == 2'd2) n_state = S_SCALE;
            S_SCALE: n_state = S_BUILD;
            S_BUILD: begin
                if (w_cnt != 3'd0) n_state = S_EMIT;
                else if (r_pix.last_pixel && r_phase != '0) n_state = S_PAD;
                else n_state = S_IDLE;
            end
            S_EMIT: begin
                if (w_load && w_emit_done) begin
                    if (r_pix.last_pixel && w_phase_next != '0) n_state = S_PAD;
                    else n_state = S_IDLE;
                end
            end
            S_PAD: if (w_load && w_phase_next == '0) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // output word
    always_comb begin
        w_slot_free  = !r_ovalid || !i_stall;
        w_phase_next = (r_phase == PHASE_W'(PAD_ALIGN - 1)) ? '0 : r_phase + 1'b1;
        w_emit_done  = ({1'b0, r_idx} + 3'd1 == r_cnt);
        w_load       = 1'b0;
        w_byte       = 8'b0;
        w_flag       = 1'b0;
        unique case (r_state)
            S_EMIT: begin
                w_load = w_slot_free;
                w_byte = r_buf[r_idx];
                w_flag = r_pix.last_pixel && w_emit_done && (w_phase_next == '0);
            end
            S_PAD: begin
                w_load = w_slot_free;
                w_flag = (w_phase_next == '0);
            end
            default: w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fmt    <= FMT_I4;
            r_thr    <= THR_RESET;
            r_step   <= 2'd0;
            r_held   <= 4'b0;
            r_odd    <= 1'b0;
            r_phase  <= '0;
            r_cnt    <= 3'd0;
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_FORMAT:    r_fmt <= t_fmt'(pwdata[2:0]);
                    REG_THRESHOLD: r_thr <= pwdata[7:0];
                    default:       r_thr <= r_thr;
                endcase
            end
            if (w_accept) begin
                r_step <= 2'd0;
            end else if (r_state == S_MAC) begin
                r_step <= r_step + 2'd1;
            end
            if (r_state == S_BUILD) begin
                r_held <= w_held;
                r_odd  <= w_odd;
                r_cnt  <= w_cnt;
                r_idx  <= 2'd0;
            end
            if (w_load) begin
                r_phase <= w_phase_next;
                if (r_state == S_EMIT) r_idx <= r_idx + 2'd1;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_pix <= i_word;
        if (r_state == S_MAC) begin
            r_acc <= ((r_step == 2'd0) ? 24'd0 : r_acc) + w_prod;
        end else if (r_state == S_SCALE) begin
            r_acc <= w_prod;
        end
        if (r_state == S_MAC && r_step == 2'd2) r_luma <= w_prod[23:16] + r_acc[23:16]
            + 8'(({8'b0, w_prod[15:0]} + {8'b0, r_acc[15:0]}) >> 16);
        if (r_state == S_BUILD) begin
            r_buf[0] <= w_buf[0];
            r_buf[1] <= w_buf[1];
            r_buf[2] <= w_buf[2];
            r_buf[3] <= w_buf[3];
        end
        if (w_load) begin
            r_oword.out_byte  <= w_byte;
            r_oword.last_byte <= w_flag;
        end
    end

endmodule

// ----- verif/tb_rgba_texel_format_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgba_texel_format_packer
// Self-checking bench for the RGBA texel format packer. Pixels go in through
// the valid/stall port with random gaps and are predicted in a scoreboard
// that keeps its own copy of the nibble pairing and padding state. Each texel
// byte taken from the output, under random stalls, is checked against the
// oldest prediction. Formats and the opacity threshold change over APB only
// while the block is drained: first a directed set, then random images.
// ----------------------------------------------------------------------------
module tb_rgba_texel_format_packer
    import rtfp_pkg::*;
();

    localparam logic [2:0] FMT_NONE = 3'd7;
    localparam int ITEMS  = 520;
    localparam int SETTLE = 24;
    localparam int LIMIT  = 1_000_000;

    class texel_scoreboard;
        logic [2:0]  fmt;
        logic [7:0]  thr;
        logic [3:0]  held;
        bit          odd;
        int unsigned fill;
        t_texel      bytes_due[$];
        int unsigned errors;
        int unsigned pixels;
        int unsigned images;
        int unsigned bytes_seen;
        bit [7:0]    fmt_seen;

        function new();
            fmt = FMT_I4;
            thr = THR_RESET;
            held = 4'h0;
            odd = 1'b0;
            fill = 0;
            errors = 0;
            pixels = 0;
            images = 0;
            bytes_seen = 0;
            fmt_seen = '0;
        endfunction

        function int unsigned quantize(input int unsigned v, input int unsigned lv);
            return (2 * v * lv + 255) / 510;
        endfunction

        function void push_byte(input logic [7:0] b);
            t_texel t;
            t.out_byte = b;
            t.last_byte = 1'b0;
            bytes_due.insert(bytes_due.size(), t);
            fill = (fill + 1) % PAD_ALIGN;
        endfunction

        function void push_nibble(input logic [3:0] nib);
            if (odd) begin
                push_byte({held, nib});
                odd = 1'b0;
                held = 4'h0;
            end else begin
                held = nib;
                odd = 1'b1;
            end
        endfunction

        function void note_pixel(input t_pixel p);
            int unsigned r, g, b, a, luma, scaled, first;
            logic        opaque;
            logic [15:0] v;
            t_texel      t;
            r = p.red;
            g = p.green;
            b = p.blue;
            a = p.alpha;
            luma = (r * LUMA_R + g * LUMA_G + b * LUMA_B) >> 16;
            scaled = luma * a / 255;
            opaque = (a >= thr);
            first = bytes_due.size();
            pixels++;
            fmt_seen[fmt] = 1'b1;
            if (fmt != FMT_I4 && fmt != FMT_IA4) begin
                odd = 1'b0;
                held = 4'h0;
            end
            case (fmt)
                FMT_I4: push_nibble(4'(quantize(scaled, LEVELS_4)));
                FMT_I8: push_byte(8'(scaled));
                FMT_IA4: push_nibble({3'(quantize(luma, LEVELS_3)), opaque});
                FMT_IA8: push_byte({4'(quantize(luma, LEVELS_4)), 4'(quantize(a, LEVELS_4))});
                FMT_IA16: begin
                    push_byte(8'(luma));
                    push_byte(8'(a));
                end
                FMT_RGBA16: begin
                    v = {5'(quantize(r, LEVELS_5)), 5'(quantize(g, LEVELS_5)),
                         5'(quantize(b, LEVELS_5)), opaque};
                    push_byte(v[15:8]);
                    push_byte(v[7:0]);
                end
                FMT_RGBA32: begin
                    push_byte(8'(r));
                    push_byte(8'(g));
                    push_byte(8'(b));
                    push_byte(8'(a));
                end
                default: ;
            endcase
            if (p.last_pixel) begin
                if (odd)
                    push_byte({held, 4'h0});
                while (fill != 0)
                    push_byte(8'h00);
                if (bytes_due.size() > first) begin
                    t = bytes_due[bytes_due.size() - 1];
                    t.last_byte = 1'b1;
                    bytes_due[bytes_due.size() - 1] = t;
                end
                held = 4'h0;
                odd = 1'b0;
                fill = 0;
                images++;
            end
        endfunction

        function void check_texel(input t_texel got);
            t_texel want;
            if (bytes_due.size() == 0) begin
                errors++;
                $display("%0t: byte %h last %b with none expected", $time,
                         got.out_byte, got.last_byte);
                return;
            end
            want = bytes_due.pop_front();
            bytes_seen++;
            if (got.out_byte !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte expected %h actual %h", $time,
                         want.out_byte, got.out_byte);
            end
            if (got.last_byte !== want.last_byte) begin
                errors++;
                $display("%0t: last_byte expected %b actual %b", $time,
                         want.last_byte, got.last_byte);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_pixel      i_word = '0;
    logic        o_stall;
    logic        o_valid;
    t_texel      o_word;
    logic        i_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    texel_scoreboard sb;
    int tx_max = 3;
    int rx_max = 3;
    int rx_hold = 0;
    int cycles = 0;

    rgba_texel_format_packer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else if (o_valid && !i_stall) begin
            rx_hold = $urandom_range(0, rx_max);
            i_stall <= (rx_hold != 0);
            if (rx_hold != 0)
                rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_texel(o_word);
    end

    function automatic t_pixel pix(input logic [7:0] r, g, b, a, input logic last);
        t_pixel p;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.alpha = a;
        p.last_pixel = last;
        return p;
    endfunction

    function automatic logic [7:0] rand_channel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 17;
        endcase
    endfunction

    task automatic write_reg(input logic idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_FORMAT)
            sb.fmt = data[2:0];
        else
            sb.thr = data[7:0];
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pixel p);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word <= p;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(p);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int len;
        int k;
        logic last;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(pix(255, 255, 255, 255, 0));
        send_pixel(pix(0, 0, 0, 0, 0));
        send_pixel(pix(255, 255, 255, 255, 1));
        drain();
        write_reg(REG_FORMAT, FMT_I8);
        write_reg(REG_THRESHOLD, 0);
        send_pixel(pix(255, 0, 0, 255, 0));
        send_pixel(pix(0, 255, 0, 128, 0));
        send_pixel(pix(0, 0, 255, 1, 1));
        drain();
        write_reg(REG_FORMAT, FMT_IA4);
        write_reg(REG_THRESHOLD, 255);
        send_pixel(pix(255, 255, 255, 255, 0));
        send_pixel(pix(128, 128, 128, 254, 0));
        send_pixel(pix(17, 34, 51, 255, 0));
        drain();
        write_reg(REG_FORMAT, FMT_IA8);
        send_pixel(pix(255, 255, 255, 0, 0));
        send_pixel(pix(0, 0, 0, 255, 1));
        drain();
        write_reg(REG_FORMAT, FMT_IA16);
        send_pixel(pix(1, 2, 3, 4, 0));
        send_pixel(pix(255, 255, 255, 255, 1));
        drain();
        write_reg(REG_FORMAT, FMT_RGBA16);
        write_reg(REG_THRESHOLD, 128);
        send_pixel(pix(255, 0, 255, 128, 0));
        send_pixel(pix(4, 3, 127, 127, 1));
        drain();
        write_reg(REG_FORMAT, FMT_RGBA32);
        send_pixel(pix(85, 170, 255, 0, 0));
        send_pixel(pix(170, 85, 0, 255, 1));
        drain();
        write_reg(REG_FORMAT, FMT_NONE);
        send_pixel(pix(1, 2, 3, 4, 1));
        drain();
        write_reg(REG_FORMAT, FMT_I4);
        send_pixel(pix(200, 100, 50, 150, 0));
        drain();
        write_reg(REG_FORMAT, FMT_NONE);
        send_pixel(pix(9, 9, 9, 9, 1));

        while (sb.pixels < ITEMS) begin
            drain();
            if ($urandom_range(0, 15) == 0)
                write_reg(REG_FORMAT, FMT_NONE);
            else
                write_reg(REG_FORMAT, $urandom_range(FMT_I4, FMT_RGBA32));
            case ($urandom_range(0, 5))
                0: write_reg(REG_THRESHOLD, 0);
                1: write_reg(REG_THRESHOLD, 255);
                2, 3: write_reg(REG_THRESHOLD, $urandom_range(0, 255));
                default: ;
            endcase
            tx_max = pick_idle();
            rx_max = pick_idle();
            len = $urandom_range(1, 24);
            for (k = 0; k < len; k++) begin
                if (k == len - 1)
                    last = ($urandom_range(0, 3) != 0);
                else
                    last = ($urandom_range(0, 15) == 0);
                send_pixel(pix(rand_channel(), rand_channel(), rand_channel(),
                               rand_channel(), last));
            end
        end
        drain();

        $display("Sent %0d pixels forming %0d images; checked %0d texel bytes",
                 sb.pixels, sb.images, sb.bytes_seen);
        $display("Format codes exercised (bit per code): %b", sb.fmt_seen);
        if (sb.errors == 0 && sb.bytes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
